### hdl/sactr_pkg.sv
// ---------------------------------------------------------------------------
// sactr_pkg
// shared types and constants for the set associative tag and replacement block
// ---------------------------------------------------------------------------
package sactr_pkg;

  localparam int MaxWays    = 8;
  localparam int MaxSets    = 1024;
  localparam int OffsetBits = 4;
  localparam int AddrBits   = 32;
  localparam int WayW       = $clog2(MaxWays);
  localparam int SetW       = $clog2(MaxSets);
  localparam int TagW       = AddrBits - OffsetBits;

  localparam logic [1:0] CfgPolicy = 2'd0;
  localparam logic [1:0] CfgWays   = 2'd1;
  localparam logic [1:0] CfgSetBits = 2'd2;

  typedef struct packed {
    logic        action;
    logic [31:0] byte_address;
  } sactr_in_t;

  typedef struct packed {
    logic        hit;
    logic [2:0]  hit_way;
    logic [31:0] access_count;
    logic [31:0] miss_count;
  } sactr_out_t;

  // classified request passed from front to back
  typedef struct packed {
    logic            clr;
    logic [SetW-1:0] set;
    logic [TagW-1:0] tag;
  } sactr_req_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE
  } sactr_state_t;

endpackage

### hdl/sactr_front.sv
// ---------------------------------------------------------------------------
// sactr_front
// splits the address into set and tag and queues requests for the back end
// ---------------------------------------------------------------------------
module sactr_front
  import sactr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [3:0] set_bits,
  input  logic       in_valid,
  output logic       in_ready,
  input  sactr_in_t  in_data,
  output logic       q_valid,
  input  logic       q_ready,
  output sactr_req_t q_data
);

  // two entry queue
  sactr_req_t       mem_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  logic [3:0]       sb;
  logic [TagW-1:0]  line;
  sactr_req_t       req;
  logic             push, pop;

  assign sb   = (set_bits > 4'(SetW)) ? 4'(SetW) : set_bits;
  assign line = in_data.byte_address[AddrBits-1:OffsetBits];

  always_comb begin
    req.clr = in_data.action;
    req.set = SetW'(line & ((TagW'(1) << sb) - TagW'(1)));
    req.tag = line >> sb;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue overflow");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !in_ready) else $error("ready when full");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |-> !q_valid) else $error("valid when empty");

endmodule

### hdl/sactr_back.sv
// ---------------------------------------------------------------------------
// sactr_back
// tag memory lookup, replacement order update and counters
// ---------------------------------------------------------------------------
module sactr_back
  import sactr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       replace_policy,
  input  logic [1:0] ways_log2,
  input  logic       q_valid,
  output logic       q_ready,
  input  sactr_req_t q_data,
  output logic       out_valid,
  input  logic       out_ready,
  output sactr_out_t out_data
);

  // one memory row holds all ways of a set, position 0 oldest
  logic [MaxWays-1:0][TagW-1:0] tag_mem [MaxSets];
  logic [MaxWays-1:0]           vld_mem [MaxSets];

  sactr_state_t                 st_r, st_nxt;
  logic [SetW:0]                clr_r, clr_nxt;
  logic                         clres_r, clres_nxt;
  sactr_req_t                   req_r;
  logic [MaxWays-1:0][TagW-1:0] row_r, row_w;
  logic [MaxWays-1:0]           vrow_r, vrow_w;
  logic [31:0]                  acc_r, acc_nxt, mis_r, mis_nxt;
  logic                         ov_r, ov_nxt;
  sactr_out_t                   od_r, od_nxt;
  logic                         rd_en, wr_en, vwr_en;
  logic [SetW-1:0]              vwr_addr;
  logic [MaxWays-1:0]           vwr_data;
  logic                         hit;
  logic [WayW-1:0]              pos;
  logic [WayW:0]                ways;
  logic [MaxWays-1:0]           wmask;

  assign ways  = (WayW+1)'(1) << ways_log2;
  assign wmask = MaxWays'((9'(1) << ways) - 9'(1));

  always_comb begin
    hit = 1'b0;
    pos = '0;
    for (int p = MaxWays - 1; p >= 0; p--) begin
      if (p < int'(ways) && vrow_r[p] && row_r[p] == req_r.tag) begin
        hit = 1'b1;
        pos = WayW'(p);
      end
    end
  end

  // new row contents: shift down from the hit or oldest position
  always_comb begin
    logic [WayW-1:0] from;
    logic [WayW-1:0] last;
    from   = hit ? pos : '0;
    last   = WayW'(ways - (WayW+1)'(1));
    row_w  = row_r;
    vrow_w = vrow_r;
    for (int p = 0; p < MaxWays - 1; p++) begin
      if (p >= int'(from) && p < int'(last)) begin
        row_w[p]  = row_r[p+1];
        vrow_w[p] = vrow_r[p+1];
      end
    end
    row_w[last]  = hit ? row_r[pos] : req_r.tag;
    vrow_w[last] = 1'b1;
    if (!hit) vrow_w = vrow_w & wmask;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      row_r  <= tag_mem[q_data.set];
      vrow_r <= vld_mem[q_data.set];
    end
    if (wr_en) tag_mem[req_r.set] <= row_w;
    if (vwr_en) vld_mem[vwr_addr] <= vwr_data;
  end

  always_comb begin
    st_nxt    = st_r;
    clr_nxt   = clr_r;
    clres_nxt = clres_r;
    acc_nxt   = acc_r;
    mis_nxt   = mis_r;
    ov_nxt    = ov_r && !out_ready;
    od_nxt    = od_r;
    q_ready   = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    vwr_en    = 1'b0;
    vwr_addr  = req_r.set;
    vwr_data  = vrow_w;
    unique case (st_r)
      ST_CLEAR: begin
        vwr_en   = 1'b1;
        vwr_addr = clr_r[SetW-1:0];
        vwr_data = '0;
        clr_nxt  = clr_r + (SetW+1)'(1);
        if (clr_r == (SetW+1)'(MaxSets - 1)) begin
          clr_nxt = clr_r;
          // the pass after reset gives no result
          if (!clres_r) begin
            st_nxt = ST_IDLE;
          end else if (!ov_nxt) begin
            st_nxt    = ST_IDLE;
            clres_nxt = 1'b0;
            ov_nxt    = 1'b1;
            od_nxt    = '0;
          end
        end
      end
      ST_IDLE: begin
        q_ready = !ov_r || out_ready;
        if (q_valid && q_ready) begin
          if (q_data.clr) begin
            acc_nxt   = '0;
            mis_nxt   = '0;
            clr_nxt   = '0;
            clres_nxt = 1'b1;
            st_nxt    = ST_CLEAR;
          end else begin
            rd_en  = 1'b1;
            st_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        st_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        if (!ov_nxt) begin
          acc_nxt = (acc_r == '1) ? acc_r : acc_r + 32'd1;
          mis_nxt = (hit || mis_r == '1) ? mis_r : mis_r + 32'd1;
          wr_en   = !hit || !replace_policy;
          vwr_en  = wr_en;
          od_nxt.hit          = hit;
          od_nxt.hit_way      = 3'(pos);
          od_nxt.access_count = acc_nxt;
          od_nxt.miss_count   = mis_nxt;
          ov_nxt  = 1'b1;
          st_nxt  = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) req_r <= q_data;
    od_r <= od_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_CLEAR;
      clr_r   <= '0;
      clres_r <= 1'b0;
      acc_r   <= '0;
      mis_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      clr_r   <= clr_nxt;
      clres_r <= clres_nxt;
      acc_r   <= acc_nxt;
      mis_r   <= mis_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

  a_clr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_CLEAR |-> acc_r == '0 && mis_r == '0) else $error("counters not cleared");
  a_mis_le: assert property (@(posedge clk) disable iff (!rst_n)
    mis_r <= acc_r) else $error("miss count above access count");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data)) else $error("result changed while held");

endmodule

### hdl/set_assoc_cache_tag_replacement.sv
// ---------------------------------------------------------------------------
// set_assoc_cache_tag_replacement
// set associative tag store with lru or fifo replacement and counters
// ---------------------------------------------------------------------------
// accepted requests pass the read and write states into the result register;
//   the write state waits while an earlier result is held; tag read, compare
//   and row write back share one port, and only then is a new request taken
// a clear request clears the valid bits of all 1024 set rows, one set row per cycle
// reset: synchronous; the same valid clearing pass runs after reset and gives
//   no result; requests queue in the front end meanwhile
module set_assoc_cache_tag_replacement
  import sactr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  sactr_in_t   in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output sactr_out_t  out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic       policy_r;
  logic [1:0] ways_log2_r;
  logic [3:0] set_bits_r;
  logic       q_valid, q_ready;
  sactr_req_t q_data;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r    <= 1'b0;
      ways_log2_r <= 2'd0;
      set_bits_r  <= 4'd6;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CfgPolicy:  policy_r    <= cfg_data[0];
        CfgWays:    ways_log2_r <= cfg_data[1:0];
        CfgSetBits: set_bits_r  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // front end: address split and request queue
  sactr_front u_front (
    .clk, .rst_n,
    .set_bits (set_bits_r),
    .in_valid, .in_ready, .in_data,
    .q_valid, .q_ready, .q_data
  );

  // back end: lookup, replacement and result register
  sactr_back u_back (
    .clk, .rst_n,
    .replace_policy (policy_r),
    .ways_log2      (ways_log2_r),
    .q_valid, .q_ready, .q_data,
    .out_valid, .out_ready, .out_data
  );

endmodule

### sim/tb_set_assoc_cache_tag_replacement.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_set_assoc_cache_tag_replacement
// drives address and clear requests through the tag store under several
// policy, associativity and set-count settings and checks every result
// against a behavioural cache model held in the bench
// ---------------------------------------------------------------------------
module tb_set_assoc_cache_tag_replacement;
  import sactr_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  sactr_in_t  in_data;
  logic       out_valid;
  logic       out_ready;
  sactr_out_t out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  set_assoc_cache_tag_replacement uut (.*);

  // clock, 8 ns period
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---- bench copy of the cache state ----
  logic [TagW-1:0] tags [MaxSets][MaxWays];
  logic [7:0]      vbits [MaxSets];
  logic [31:0]     acc_cnt, miss_cnt;
  logic            pol;
  logic [1:0]      wl_reg;
  logic [3:0]      sb_reg;

  sactr_out_t expected_q[$];
  int         fails;
  logic       hold_off;

  function automatic logic [31:0] inc_sat(logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  // models one request and returns the result it should produce
  function automatic sactr_out_t lookup(sactr_in_t r);
    sactr_out_t      res;
    int              sb, ways, pos, s;
    logic [TagW-1:0] tg, t;
    logic [7:0]      v, wm, lo, hi;
    logic            found;
    res = '0;
    if (r.action) begin
      foreach (vbits[i]) vbits[i] = '0;
      acc_cnt  = '0;
      miss_cnt = '0;
      return res;
    end
    sb    = (sb_reg > 10) ? 10 : sb_reg;
    ways  = 1 << wl_reg;
    wm    = 8'((16'd1 << ways) - 1);
    tg    = TagW'(r.byte_address >> (OffsetBits + sb));
    s     = int'((r.byte_address >> OffsetBits) & ((32'd1 << sb) - 1));
    v     = vbits[s];
    found = 1'b0;
    pos   = 0;
    for (int p = 0; p < ways; p++) begin
      if (!found && v[p] && tags[s][p] == tg) begin
        found = 1'b1;
        pos   = p;
      end
    end
    acc_cnt = inc_sat(acc_cnt);
    if (!found) begin
      miss_cnt = inc_sat(miss_cnt);
      for (int p = 0; p + 1 < ways; p++) tags[s][p] = tags[s][p+1];
      tags[s][ways-1] = tg;
      vbits[s] = ((v & wm) >> 1) | (8'd1 << (ways - 1));
    end else if (pol == 1'b0) begin
      t  = tags[s][pos];
      lo = v & 8'((16'd1 << pos) - 1);
      hi = (v & wm) >> (pos + 1);
      for (int p = pos; p + 1 < ways; p++) tags[s][p] = tags[s][p+1];
      tags[s][ways-1] = t;
      vbits[s] = (v & ~wm) | lo | (hi << pos) | (8'd1 << (ways - 1));
    end
    res.hit          = found;
    res.hit_way      = 3'(pos);
    res.access_count = acc_cnt;
    res.miss_count   = miss_cnt;
    return res;
  endfunction

  // ---- result checking, receiver stalls on its own pattern ----
  int stall_ph;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_ph  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t unexpected result %p", $time, out_data);
          fails++;
        end else begin
          sactr_out_t e;
          e = expected_q.pop_front();
          if (out_data.hit !== e.hit)
            $display("%0t hit exp %0d got %0d", $time, e.hit, out_data.hit);
          if (out_data.hit_way !== e.hit_way)
            $display("%0t hit_way exp %0d got %0d", $time, e.hit_way, out_data.hit_way);
          if (out_data.access_count !== e.access_count)
            $display("%0t access_count exp %0h got %0h", $time, e.access_count,
                     out_data.access_count);
          if (out_data.miss_count !== e.miss_count)
            $display("%0t miss_count exp %0h got %0h", $time, e.miss_count,
                     out_data.miss_count);
          if (out_data !== e) fails++;
        end
      end
      // pattern: runs of ready broken by short stalls, phase drifts
      stall_ph  <= stall_ph + 1;
      out_ready <= !hold_off && (((stall_ph % 13) > 3) || ($urandom_range(0, 3) == 0));
    end
  end

  // ---- request driving ----
  // valid stays high on return; the caller drops it before any gap
  task automatic send(sactr_in_t r);
    in_valid <= 1'b1;
    in_data  <= r;
    expected_q.insert(expected_q.size(), lookup(r));
    do @(posedge clk); while (!in_ready);
  endtask

  // typed-in expectation for rows that can be read off at a glance
  task automatic send_known(sactr_in_t r, sactr_out_t k);
    sactr_out_t p;
    in_valid <= 1'b1;
    in_data  <= r;
    p = lookup(r);
    if (p !== k) begin
      $display("%0t directed row exp %p model %p", $time, k, p);
      fails++;
    end
    expected_q.insert(expected_q.size(), k);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    // a clear pass is over by the time its result is given
    repeat (1100) @(posedge clk);
  endtask

  // valid stays high on return; the caller drops it after the last write
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CfgPolicy:  pol    = val[0];
      CfgWays:    wl_reg = val[1:0];
      CfgSetBits: sb_reg = val[3:0];
      default: ;
    endcase
  endtask

  function automatic sactr_in_t acc(logic [31:0] a);
    sactr_in_t r;
    r.action       = 1'b0;
    r.byte_address = a;
    return r;
  endfunction

  // random address from a small pool so that sets collide and tags recur
  function automatic logic [31:0] rand_addr();
    logic [31:0] a;
    if ($urandom_range(0, 9) == 0) return $urandom();
    a = 32'($urandom_range(0, 5)) << (8 + $urandom_range(0, 10));
    a = a | (32'($urandom_range(0, 3)) << 4) | 32'($urandom_range(0, 15));
    if ($urandom_range(0, 3) == 0) a[31] = ~a[31];
    return a;
  endfunction

  typedef struct {
    sactr_in_t  req;
    logic       known;
    sactr_out_t res;
  } row_t;

  row_t rows[$];
  int   burst;

  initial begin
    sactr_in_t clr_req;
    int        gap;
    clr_req = '{action: 1'b1, byte_address: 32'hFFFF_FFFF};
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0;
    cfg_valid = 1'b0; cfg_index = CfgPolicy; cfg_data = '0;
    hold_off = 1'b0; fails = 0; burst = 0;
    foreach (vbits[i]) vbits[i] = '0;
    foreach (tags[i, j]) tags[i][j] = '0;
    acc_cnt = '0; miss_cnt = '0; pol = 1'b0; wl_reg = '0; sb_reg = 4'd6;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: first miss after reset, extremes, clear, hit
    rows.insert(rows.size(), '{acc(32'h0),         1'b1, '{1'b0, 3'd0, 32'd1, 32'd1}});
    rows.insert(rows.size(), '{acc(32'h0000_000F), 1'b1, '{1'b1, 3'd0, 32'd2, 32'd1}});
    rows.insert(rows.size(), '{acc(32'hFFFF_FFFF), 1'b1, '{1'b0, 3'd0, 32'd3, 32'd2}});
    rows.insert(rows.size(), '{acc(32'h0000_0400), 1'b1, '{1'b0, 3'd0, 32'd4, 32'd3}});
    rows.insert(rows.size(), '{acc(32'h0),         1'b1, '{1'b0, 3'd0, 32'd5, 32'd4}});
    rows.insert(rows.size(), '{clr_req,            1'b1, '{1'b0, 3'd0, 32'd0, 32'd0}});
    rows.insert(rows.size(), '{acc(32'hFFFF_FFF0), 1'b1, '{1'b0, 3'd0, 32'd1, 32'd1}});
    rows.insert(rows.size(), '{acc(32'hAAAA_5555), 1'b0, '0});
    rows.insert(rows.size(), '{acc(32'h5555_AAAA), 1'b0, '0});
    foreach (rows[i]) begin
      if (rows[i].known) send_known(rows[i].req, rows[i].res);
      else send(rows[i].req);
    end
    drain();

    // several settings, extremes included; oversize set count saturates
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CfgPolicy, {31'd0, ph[0]});
      write_reg(CfgWays, (ph == 0) ? 32'd3 : (ph == 1) ? 32'd0 : $urandom_range(0, 3));
      write_reg(CfgSetBits, (ph == 2) ? 32'd15 : (ph == 3) ? 32'd0 :
                (ph == 4) ? 32'd10 : $urandom_range(0, 12));
      if (ph == 5) write_reg(CfgWays, 32'd1);  // ways changed to two while sets hold data
      cfg_valid <= 1'b0;
      for (int n = 0; n < 250; n++) begin
        sactr_in_t r;
        // a long receiver hold off while requests keep coming
        if (ph == 2 && n == 20) begin
          fork
            begin
              hold_off = 1'b1;
              repeat (200) @(posedge clk);
              hold_off = 1'b0;
            end
          join_none
        end
        // sender pauses until everything is back
        if (ph == 4 && n == 100 && expected_q.size() != 0) begin
          in_valid <= 1'b0;
          while (expected_q.size() != 0) @(posedge clk);
        end
        if (burst <= 0) begin
          gap = $urandom_range(0, 6);
          if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          burst = $urandom_range(1, 20);
        end
        burst--;
        r = acc(rand_addr());
        if ($urandom_range(0, 99) == 0) r.action = 1'b1;
        send(r);
      end
      drain();
    end

    if (fails == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule

### filelist.f
hdl/sactr_pkg.sv
hdl/sactr_front.sv
hdl/sactr_back.sv
hdl/set_assoc_cache_tag_replacement.sv
sim/tb_set_assoc_cache_tag_replacement.sv
